/* rtl/core/dtf_pkg.sv */
// Shared types, constants and the two-digit ASCII helper for the
// timestamp text formatter. No dependencies.
`default_nettype none

package dtf_pkg;

   localparam int unsigned TEXT_LEN = 32;
   localparam int unsigned CNT_W    = $clog2(TEXT_LEN);

   localparam logic [13:0] YEAR_MAX   = 14'd9999;
   localparam logic [3:0]  MONTH_MAX  = 4'd12;
   localparam logic [4:0]  HOUR_MAX   = 5'd23;
   localparam logic [5:0]  MINSEC_MAX = 6'd59;
   localparam logic [19:0] USEC_MAX   = 20'd999999;
   localparam logic [11:0] OFFSET_MAX = 12'd1439;

   // reciprocal constants: q = (x * RECIP) >> SHIFT, exact over the used range
   localparam logic [11:0] DIV60_RECIP    = 12'd2185;     // >> 17, x < 4681
   localparam logic [13:0] DIV100_RECIP   = 14'd10486;    // >> 20, x < 43690
   localparam logic [20:0] DIV1000_RECIP  = 21'd1073742;  // >> 30, x < 6.1e6
   localparam logic [5:0]  DIV100S_RECIP  = 6'd41;        // >> 12, x < 1024
   localparam logic [7:0]  DIV10_RECIP    = 8'd205;       // >> 11, x < 1029

   localparam logic [7:0] CH_ZERO  = 8'h30;
   localparam logic [7:0] CH_DASH  = 8'h2D;
   localparam logic [7:0] CH_PLUS  = 8'h2B;
   localparam logic [7:0] CH_COLON = 8'h3A;
   localparam logic [7:0] CH_DOT   = 8'h2E;
   localparam logic [7:0] CH_T     = 8'h54;

   // input item after the check stage
   typedef struct packed {
      logic [13:0] year;
      logic [3:0]  month;
      logic [4:0]  day;
      logic [4:0]  hour;
      logic [5:0]  minute;
      logic [5:0]  second;
      logic [19:0] usec;
      logic        neg;
      logic [11:0] mag;
      logic        err;
   } fields_type;

   // every value reduced to a digit or a 0..99 pair
   typedef struct packed {
      logic [6:0] yh;
      logic [6:0] yl;
      logic [3:0] month;
      logic [4:0] day;
      logic [4:0] hour;
      logic [5:0] minute;
      logic [5:0] second;
      logic [3:0] u_d0;
      logic [6:0] u_hr;
      logic [3:0] u_d3;
      logic [6:0] u_lr;
      logic       neg;
      logic [5:0] oh;
      logic [5:0] om;
      logic       err;
   } parts_type;

   typedef struct packed {
      logic [8*TEXT_LEN-1:0] text;   // byte 0 in the low bits
      logic                  err;
   } text_type;

   function automatic logic [7:0] digit_ascii(input logic [3:0] d);
      digit_ascii = CH_ZERO | {4'b0000, d};
   endfunction

   // 0..99 -> two ASCII digits, tens in the low byte
   function automatic logic [15:0] two_ascii(input logic [6:0] x);
      logic [14:0] prod;
      logic [3:0]  tens;
      logic [3:0]  ones;
      prod = 15'(x) * 15'(DIV10_RECIP);
      tens = prod[14:11];
      ones = 4'(x - 7'(7'(tens) * 7'd10));
      two_ascii = {digit_ascii(ones), digit_ascii(tens)};
   endfunction

endpackage

`default_nettype wire

/* rtl/core/dtf_check.sv */
// Input register stage: range check and offset magnitude.
// Depends on dtf_pkg.
`default_nettype none

module dtf_check (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               in_valid,
   output logic                    in_ready,
   input  wire logic [13:0]        year,
   input  wire logic [3:0]         month,
   input  wire logic [4:0]         day,
   input  wire logic [4:0]         hour,
   input  wire logic [5:0]         minute,
   input  wire logic [5:0]         second,
   input  wire logic [19:0]        usec,
   input  wire logic [11:0]        offset,
   output logic                    out_valid,
   input  wire logic               out_ready,
   output dtf_pkg::fields_type     out_data
);

   logic                valid_ff;
   dtf_pkg::fields_type data_ff, data_in;
   logic [11:0]         mag;

   always_comb begin
      mag = offset[11] ? 12'(~offset + 12'd1) : offset;
      data_in.year   = year;
      data_in.month  = month;
      data_in.day    = day;
      data_in.hour   = hour;
      data_in.minute = minute;
      data_in.second = second;
      data_in.usec   = usec;
      data_in.neg    = offset[11];
      data_in.mag    = mag;
      data_in.err    = (year == 14'd0) || (year > dtf_pkg::YEAR_MAX)
                    || (month == 4'd0) || (month > dtf_pkg::MONTH_MAX)
                    || (day == 5'd0) || (hour > dtf_pkg::HOUR_MAX)
                    || (minute > dtf_pkg::MINSEC_MAX)
                    || (second > dtf_pkg::MINSEC_MAX)
                    || (usec > dtf_pkg::USEC_MAX)
                    || (mag > dtf_pkg::OFFSET_MAX);
   end

   assign in_ready  = !valid_ff || out_ready;
   assign out_valid = valid_ff;
   assign out_data  = data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready) begin
         data_ff <= data_in;
      end
   end

endmodule

`default_nettype wire

/* rtl/core/dtf_divide.sv */
// Four-stage reciprocal divide pipeline: splits year, microseconds and
// offset into 0..99 pairs and single digits. Depends on dtf_pkg.
`default_nettype none

module dtf_divide (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               in_valid,
   output logic                    in_ready,
   input  wire dtf_pkg::fields_type in_data,
   output logic                    out_valid,
   input  wire logic               out_ready,
   output dtf_pkg::parts_type      out_data
);

   // stage a: quotients
   logic                a_valid_ff;
   dtf_pkg::fields_type a_f_ff;
   logic [5:0]          a_oh_ff;
   logic [7:0]          a_yh_ff;
   logic [10:0]         a_uh_ff;
   // stage b: remainders, hundreds of the upper microsecond half
   logic                b_valid_ff;
   dtf_pkg::fields_type b_f_ff;
   logic [5:0]          b_oh_ff, b_om_ff;
   logic [7:0]          b_yh_ff;
   logic [6:0]          b_yl_ff;
   logic [9:0]          b_uh_ff, b_ul_ff;
   logic [3:0]          b_uhh_ff;
   // stage c
   logic                c_valid_ff;
   dtf_pkg::parts_type  c_p_ff;
   logic [9:0]          c_ul_ff;
   // stage d
   logic                d_valid_ff;
   dtf_pkg::parts_type  d_p_ff, d_p_in;

   logic a_ready, b_ready, c_ready, d_ready;

   logic [23:0] oh_prod;
   logic [27:0] yh_prod;
   logic [40:0] uh_prod;
   logic [15:0] uhh_prod, ulh_prod;
   logic [9:0]  ul_in;

   assign d_ready  = !d_valid_ff || out_ready;
   assign c_ready  = !c_valid_ff || d_ready;
   assign b_ready  = !b_valid_ff || c_ready;
   assign a_ready  = !a_valid_ff || b_ready;
   assign in_ready = a_ready;

   assign out_valid = d_valid_ff;
   assign out_data  = d_p_ff;

   always_comb begin
      oh_prod  = 24'(in_data.mag) * 24'(dtf_pkg::DIV60_RECIP);
      yh_prod  = 28'(in_data.year) * 28'(dtf_pkg::DIV100_RECIP);
      uh_prod  = 41'(in_data.usec) * 41'(dtf_pkg::DIV1000_RECIP);
      uhh_prod = 16'(a_uh_ff[9:0]) * 16'(dtf_pkg::DIV100S_RECIP);
      ul_in    = 10'(a_f_ff.usec - 20'(20'(a_uh_ff) * 20'd1000));
      ulh_prod = 16'(b_ul_ff) * 16'(dtf_pkg::DIV100S_RECIP);
      d_p_in      = c_p_ff;
      d_p_in.u_lr = 7'(c_ul_ff - 10'(10'(c_p_ff.u_d3) * 10'd100));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
         b_valid_ff <= 1'b0;
         c_valid_ff <= 1'b0;
         d_valid_ff <= 1'b0;
      end else begin
         if (a_ready) begin
            a_valid_ff <= in_valid;
         end
         if (b_ready) begin
            b_valid_ff <= a_valid_ff;
         end
         if (c_ready) begin
            c_valid_ff <= b_valid_ff;
         end
         if (d_ready) begin
            d_valid_ff <= c_valid_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (a_ready) begin
         a_f_ff  <= in_data;
         a_oh_ff <= oh_prod[22:17];
         a_yh_ff <= yh_prod[27:20];
         a_uh_ff <= uh_prod[40:30];
      end
      if (b_ready) begin
         b_f_ff   <= a_f_ff;
         b_oh_ff  <= a_oh_ff;
         b_om_ff  <= 6'(a_f_ff.mag - 12'(12'(a_oh_ff) * 12'd60));
         b_yh_ff  <= a_yh_ff;
         b_yl_ff  <= 7'(a_f_ff.year - 14'(14'(a_yh_ff) * 14'd100));
         b_uh_ff  <= a_uh_ff[9:0];
         b_ul_ff  <= ul_in;
         b_uhh_ff <= uhh_prod[15:12];
      end
      if (c_ready) begin
         c_p_ff.yh     <= b_yh_ff[6:0];
         c_p_ff.yl     <= b_yl_ff;
         c_p_ff.month  <= b_f_ff.month;
         c_p_ff.day    <= b_f_ff.day;
         c_p_ff.hour   <= b_f_ff.hour;
         c_p_ff.minute <= b_f_ff.minute;
         c_p_ff.second <= b_f_ff.second;
         c_p_ff.u_d0   <= b_uhh_ff;
         c_p_ff.u_hr   <= 7'(b_uh_ff - 10'(10'(b_uhh_ff) * 10'd100));
         c_p_ff.u_d3   <= ulh_prod[15:12];
         c_p_ff.u_lr   <= 7'd0;
         c_p_ff.neg    <= b_f_ff.neg;
         c_p_ff.oh     <= b_oh_ff;
         c_p_ff.om     <= b_om_ff;
         c_p_ff.err    <= b_f_ff.err;
         c_ul_ff       <= b_ul_ff;
      end
      if (d_ready) begin
         d_p_ff <= d_p_in;
      end
   end

endmodule

`default_nettype wire

/* rtl/core/dtf_digits.sv */
// Text assembly stage: turns the digit groups into the 32-byte line.
// Depends on dtf_pkg.
`default_nettype none

module dtf_digits (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               in_valid,
   output logic                    in_ready,
   input  wire dtf_pkg::parts_type in_data,
   output logic                    out_valid,
   input  wire logic               out_ready,
   output dtf_pkg::text_type       out_data
);

   logic              valid_ff;
   dtf_pkg::text_type data_ff, data_in;
   logic [7:0]        sign_ch;

   always_comb begin
      sign_ch = in_data.neg ? dtf_pkg::CH_DASH : dtf_pkg::CH_PLUS;
      // listed from the last character down to the first
      data_in.text = {
         dtf_pkg::two_ascii(7'(in_data.om)),
         dtf_pkg::CH_COLON,
         dtf_pkg::two_ascii(7'(in_data.oh)),
         sign_ch,
         dtf_pkg::two_ascii(in_data.u_lr),
         dtf_pkg::digit_ascii(in_data.u_d3),
         dtf_pkg::two_ascii(in_data.u_hr),
         dtf_pkg::digit_ascii(in_data.u_d0),
         dtf_pkg::CH_DOT,
         dtf_pkg::two_ascii(7'(in_data.second)),
         dtf_pkg::CH_COLON,
         dtf_pkg::two_ascii(7'(in_data.minute)),
         dtf_pkg::CH_COLON,
         dtf_pkg::two_ascii(7'(in_data.hour)),
         dtf_pkg::CH_T,
         dtf_pkg::two_ascii(7'(in_data.day)),
         dtf_pkg::CH_DASH,
         dtf_pkg::two_ascii(7'(in_data.month)),
         dtf_pkg::CH_DASH,
         dtf_pkg::two_ascii(in_data.yl),
         dtf_pkg::two_ascii(in_data.yh)
      };
      data_in.err = in_data.err;
   end

   assign in_ready  = !valid_ff || out_ready;
   assign out_valid = valid_ff;
   assign out_data  = data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready) begin
         data_ff <= data_in;
      end
   end

endmodule

`default_nettype wire

/* rtl/core/dtf_serial.sv */
// Output serializer: holds one formatted line and shifts it out one
// byte per item; an error line goes out as a single item. Depends on dtf_pkg.
`default_nettype none

module dtf_serial (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              in_valid,
   output logic                   in_ready,
   input  wire dtf_pkg::text_type in_data,
   output logic                   out_valid,
   input  wire logic              out_ready,
   output logic [7:0]             out_byte,
   output logic                   out_last,
   output logic                   out_err
);

   logic                              valid_ff;
   logic [8*dtf_pkg::TEXT_LEN-1:0]    text_ff;
   logic                              err_ff;
   logic [dtf_pkg::CNT_W-1:0]         cnt_ff;

   assign out_valid = valid_ff;
   assign out_err   = err_ff;
   assign out_byte  = err_ff ? 8'd0 : text_ff[7:0];
   assign out_last  = err_ff || (cnt_ff == dtf_pkg::CNT_W'(dtf_pkg::TEXT_LEN - 1));
   // next line loads while the final byte is being taken
   assign in_ready  = !valid_ff || (out_ready && out_last);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         cnt_ff   <= '0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
         cnt_ff   <= '0;
      end else if (out_ready) begin
         cnt_ff <= cnt_ff + dtf_pkg::CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready) begin
         text_ff <= in_data.text;
         err_ff  <= in_data.err;
      end else if (out_ready) begin
         text_ff <= {8'd0, text_ff[8*dtf_pkg::TEXT_LEN-1:8]};
      end
   end

endmodule

`default_nettype wire

/* rtl/core/datetime_text_formatter_core.sv */
// Timestamp text formatter, top level.
// Input channel req_*: one broken-down timestamp per item (year, month,
// day, hour, minute, second, microsecond, UTC offset in minutes).
// Result channel rsp_*: one ASCII byte per item, the 32-character line
// YYYY-MM-DDTHH:MM:SS.uuuuuu+HH:MM, tlast on the final byte. A timestamp
// with any field out of range gives one item instead: data 0, tlast 1,
// tuser (range error) 1.
// Pipeline: six register stages (check, four reciprocal-divide stages,
// text assembly) and then the serializer. Throughput: one byte per cycle
// while rsp_tready is high, set by the byte-wide result channel; a valid
// timestamp gives 32 bytes and a rejected one a single item. The
// serializer reloads while its final byte is taken, so lines leave with
// no gap, and further timestamps queue in the pipeline stages meanwhile.
// Reset (synchronous) empties every stage. When the receiver drops
// rsp_tready the current byte holds, the stages fill up and req_tready
// falls; nothing is lost or repeated.
// Depends on dtf_pkg, dtf_check, dtf_divide, dtf_digits, dtf_serial.
`default_nettype none

module datetime_text_formatter_core (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   // year[13:0], month[17:14], day[22:18], hour[27:23], minute[33:28],
   // second[39:34], microsecond[59:40], offset_minutes[71:60]
   input  wire logic [71:0] req_tdata,
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [7:0]       rsp_tdata,   // text_byte[7:0]
   output logic             rsp_tlast,   // last
   output logic             rsp_tuser    // range_error
);

   logic                chk_valid, chk_ready;
   dtf_pkg::fields_type chk_data;
   logic                div_valid, div_ready;
   dtf_pkg::parts_type  div_data;
   logic                dig_valid, dig_ready;
   dtf_pkg::text_type   dig_data;

   dtf_check u_check (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_tvalid),
      .in_ready  (req_tready),
      .year      (req_tdata[13:0]),
      .month     (req_tdata[17:14]),
      .day       (req_tdata[22:18]),
      .hour      (req_tdata[27:23]),
      .minute    (req_tdata[33:28]),
      .second    (req_tdata[39:34]),
      .usec      (req_tdata[59:40]),
      .offset    (req_tdata[71:60]),
      .out_valid (chk_valid),
      .out_ready (chk_ready),
      .out_data  (chk_data)
   );

   dtf_divide u_divide (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (chk_valid),
      .in_ready  (chk_ready),
      .in_data   (chk_data),
      .out_valid (div_valid),
      .out_ready (div_ready),
      .out_data  (div_data)
   );

   dtf_digits u_digits (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (div_valid),
      .in_ready  (div_ready),
      .in_data   (div_data),
      .out_valid (dig_valid),
      .out_ready (dig_ready),
      .out_data  (dig_data)
   );

   dtf_serial u_serial (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (dig_valid),
      .in_ready  (dig_ready),
      .in_data   (dig_data),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .out_byte  (rsp_tdata),
      .out_last  (rsp_tlast),
      .out_err   (rsp_tuser)
   );

endmodule

`default_nettype wire
